[rtl/rbf_pkg.sv]
// Package for the rotating Bloom filter: default sizes, command and
// register codes, controller states and the one-at-a-time hash steps.
// No dependencies.
package rbf_pkg;

  localparam int FILTER_SIZE_DEF   = 16384;
  localparam int MAX_HASHES_DEF    = 8;
  localparam int MAX_FILTERS_DEF   = 4;
  localparam int MAX_KEY_BYTES_DEF = 64;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int HASH_W     = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_CHECK  = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [CFG_ADDR_W-1:0] REG_HASH_SEED    = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HASH_COUNT   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_BITS  = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_FILTER_COUNT = 4'd3;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_KRD,
    ST_KMIX,
    ST_FIN,
    ST_MOD,
    ST_FRD,
    ST_FUPD,
    ST_DONE,
    ST_CLRD,
    ST_CLWR
  } state_t;

  function automatic logic [HASH_W-1:0] oaat_mix(input logic [HASH_W-1:0] h,
                                                 input logic [7:0] b);
    logic [HASH_W-1:0] t;
    t = h + HASH_W'(b);
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] oaat_final(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

[rtl/rbf_if.sv]
// Channel interfaces: key items in, results out, register writes.
// Depends on rbf_pkg.
interface rbf_in_if import rbf_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t cmd;
  logic [7:0] key_byte;
  logic carries_byte;
  logic last;
  modport source (output valid, cmd, key_byte, carries_byte, last, input ready);
  modport sink (input valid, cmd, key_byte, carries_byte, last, output ready);
endinterface

interface rbf_out_if;
  logic valid;
  logic ready;
  logic found;
  logic key_too_long;
  modport source (output valid, found, key_too_long, input ready);
  modport sink (input valid, found, key_too_long, output ready);
endinterface

interface rbf_cfg_if import rbf_pkg::*; ();
  logic valid;
  logic ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

[rtl/rbf_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/rbf_mod.sv]
// Iterative remainder unit: 32-bit hash modulo the bit count, one bit a cycle.
// Depends on rbf_pkg.
module rbf_mod import rbf_pkg::*; #(
  parameter int CW = 15,
  parameter int IW = 14
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [CW-1:0]     divisor,
  output logic              done,
  output logic [IW-1:0]     rem
);
  localparam int CNT_W = $clog2(HASH_W);

  logic [CW-1:0]     rem_r, rem_nxt;
  logic [HASH_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CW:0]       rem_sh;

  always_comb begin
    rem_sh   = {rem_r, quo_r[HASH_W-1]};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = CW'(rem_sh - {1'b0, divisor});
      end else begin
        rem_nxt = CW'(rem_sh);
      end
      quo_nxt = quo_r << 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(HASH_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[IW-1:0];
endmodule

[rtl/rotating_bloom_filter_top.sv]
// Rotating Bloom filter top: key buffer RAM, filter RAM, hash sequencer.
// Depends on rbf_pkg, rbf_if, rbf_ram, rbf_mod.
//
//  channel | dir | word
//  in_ch   | in  | cmd, key_byte, carries_byte, last
//  out_ch  | out | found, key_too_long
//  cfg_ch  | in  | addr, data
//
// Byte without last: taken, no hashing. Rotate: a sweep of all filter RAM
// rows clears the current filter; the next becomes current. Key with last:
// per round the key bytes are mixed in via the key RAM, the remainder unit
// reduces the hash and the filter RAM row is read; a check tests the bit,
// an insert sets it in each active filter. After reset all filter RAM rows
// are zeroed, taking no word. A stalled result holds in the output register.
module rotating_bloom_filter_top import rbf_pkg::*; #(
  parameter int FILTER_SIZE   = FILTER_SIZE_DEF,
  parameter int MAX_HASHES    = MAX_HASHES_DEF,
  parameter int MAX_FILTERS   = MAX_FILTERS_DEF,
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rbf_in_if.sink    in_ch,
  rbf_out_if.source out_ch,
  rbf_cfg_if.sink   cfg_ch
);
  localparam int IW    = $clog2(FILTER_SIZE);
  localparam int ROWS  = FILTER_SIZE / 8;
  localparam int RAW   = $clog2(ROWS);
  localparam int CW    = (IW + 1 > 15) ? IW + 1 : 15;
  localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int NW    = $clog2(MAX_FILTERS + 1);
  localparam int LW    = $clog2(MAX_KEY_BYTES + 1);
  localparam int KAW   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int ROW_W = MAX_FILTERS * 8;

  logic [31:0] seed_r;
  logic [3:0]  hcount_r;
  logic [14:0] fbits_r;
  logic [2:0]  fcount_r;

  state_t            state_r, state_nxt;
  logic [FW-1:0]     cur_r, cur_nxt;
  logic [FW-1:0]     clr_r, clr_nxt;
  logic [NW-1:0]     ncur_r, ncur_nxt;
  logic [LW-1:0]     klen_r, klen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LW-1:0]     bi_r, bi_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic [3:0]        round_r, round_nxt;
  logic [3:0]        rounds_r, rounds_nxt;
  logic              chk_r, chk_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [RAW-1:0]    row_r, row_nxt;
  logic              ov_r, ov_nxt;
  logic              of_r, of_nxt;
  logic              ok_r, ok_nxt;

  logic [CW-1:0]     bits_use;
  logic [NW-1:0]     count_use;
  logic [3:0]        rounds_use;
  logic              accept;
  logic              mod_start, mod_done;
  logic [IW-1:0]     mod_rem;
  logic [HASH_W-1:0] h_fin;
  logic [LW-1:0]     klen_add;
  logic              ovf_add;

  logic              kb_we, kb_re;
  logic [KAW-1:0]    kb_raddr;
  logic [7:0]        kb_rdata;
  logic              fm_we, fm_re;
  logic [RAW-1:0]    fm_waddr, fm_raddr;
  logic [ROW_W-1:0]  fm_wdata, fm_rdata;
  logic [7:0]        cur_byte;
  logic [7:0]        bit_mask;

  always_comb begin
    if (fbits_r < 15'd8) begin
      bits_use = CW'(8);
    end else if (32'(fbits_r) > FILTER_SIZE) begin
      bits_use = CW'(FILTER_SIZE);
    end else begin
      bits_use = CW'(fbits_r);
    end
    if (fcount_r == 3'd0) begin
      count_use = NW'(1);
    end else if (32'(fcount_r) > MAX_FILTERS) begin
      count_use = NW'(MAX_FILTERS);
    end else begin
      count_use = NW'(fcount_r);
    end
    if (32'(hcount_r) > MAX_HASHES) begin
      rounds_use = 4'(MAX_HASHES);
    end else begin
      rounds_use = hcount_r;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= '0;
      hcount_r <= 4'd5;
      fbits_r  <= 15'd16384;
      fcount_r <= 3'd3;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        REG_HASH_SEED:    seed_r   <= cfg_ch.data;
        REG_HASH_COUNT:   hcount_r <= cfg_ch.data[3:0];
        REG_FILTER_BITS:  fbits_r  <= cfg_ch.data[14:0];
        REG_FILTER_COUNT: fcount_r <= cfg_ch.data[2:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign h_fin       = oaat_final(h_r);
  assign bit_mask    = 8'(1) << idx_r[2:0];

  always_comb begin
    klen_add = klen_r;
    ovf_add  = ovf_r;
    if (in_ch.carries_byte) begin
      if (klen_r < LW'(MAX_KEY_BYTES)) begin
        klen_add = klen_r + LW'(1);
      end else begin
        ovf_add = 1'b1;
      end
    end
  end

  always_comb begin
    cur_byte = '0;
    for (int f = 0; f < MAX_FILTERS; f++) begin
      if (FW'(f) == cur_r) begin
        cur_byte = fm_rdata[f*8 +: 8];
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    clr_nxt    = clr_r;
    ncur_nxt   = ncur_r;
    klen_nxt   = klen_r;
    ovf_nxt    = ovf_r;
    bi_nxt     = bi_r;
    h_nxt      = h_r;
    round_nxt  = round_r;
    rounds_nxt = rounds_r;
    chk_nxt    = chk_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    row_nxt    = row_r;
    ov_nxt     = ov_r;
    of_nxt     = of_r;
    ok_nxt     = ok_r;
    mod_start  = 1'b0;
    kb_we      = 1'b0;
    kb_re      = 1'b0;
    kb_raddr   = bi_r[KAW-1:0];
    fm_we      = 1'b0;
    fm_re      = 1'b0;
    fm_waddr   = row_r;
    fm_raddr   = row_r;
    fm_wdata   = fm_rdata;

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT: begin
        fm_we    = 1'b1;
        fm_wdata = '0;
        row_nxt  = row_r + RAW'(1);
        if (row_r == RAW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority case (in_ch.cmd)
            CMD_ROTATE: begin
              clr_nxt   = cur_r;
              ncur_nxt  = NW'(cur_r) + NW'(1);
              row_nxt   = '0;
              state_nxt = ST_CLRD;
            end
            CMD_INSERT, CMD_CHECK: begin
              kb_we    = in_ch.carries_byte && (klen_r < LW'(MAX_KEY_BYTES));
              klen_nxt = klen_add;
              ovf_nxt  = ovf_add;
              if (in_ch.last) begin
                chk_nxt    = (in_ch.cmd == CMD_CHECK);
                h_nxt      = seed_r;
                round_nxt  = '0;
                rounds_nxt = rounds_use;
                found_nxt  = 1'b1;
                bi_nxt     = '0;
                state_nxt  = (rounds_use == 4'd0) ? ST_DONE : ST_KRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_KRD: begin
        if (bi_r == klen_r) begin
          state_nxt = ST_FIN;
        end else begin
          kb_re     = 1'b1;
          state_nxt = ST_KMIX;
        end
      end
      ST_KMIX: begin
        h_nxt     = oaat_mix(h_r, kb_rdata);
        bi_nxt    = bi_r + LW'(1);
        state_nxt = ST_KRD;
      end
      ST_FIN: begin
        h_nxt     = h_fin;
        mod_start = 1'b1;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          state_nxt = ST_FRD;
        end
      end
      ST_FRD: begin
        fm_re     = 1'b1;
        fm_raddr  = RAW'(idx_r >> 3);
        state_nxt = ST_FUPD;
      end
      ST_FUPD: begin
        fm_waddr = RAW'(idx_r >> 3);
        if (chk_r) begin
          if ((cur_byte & bit_mask) == 8'd0) begin
            found_nxt = 1'b0;
          end
        end else begin
          fm_we = 1'b1;
          for (int f = 0; f < MAX_FILTERS; f++) begin
            if (NW'(f) < count_use) begin
              fm_wdata[f*8 +: 8] = fm_rdata[f*8 +: 8] | bit_mask;
            end
          end
        end
        round_nxt = round_r + 4'd1;
        bi_nxt    = '0;
        state_nxt = (round_r + 4'd1 == rounds_r) ? ST_DONE : ST_KRD;
      end
      ST_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          of_nxt    = chk_r && found_r;
          ok_nxt    = ovf_r;
          klen_nxt  = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLRD: begin
        fm_re = 1'b1;
        if (ncur_r >= count_use) begin
          ncur_nxt = ncur_r - count_use;
        end
        state_nxt = ST_CLWR;
      end
      ST_CLWR: begin
        fm_we = 1'b1;
        for (int f = 0; f < MAX_FILTERS; f++) begin
          if (FW'(f) == clr_r) begin
            fm_wdata[f*8 +: 8] = 8'd0;
          end
        end
        if (ncur_r >= count_use) begin
          ncur_nxt = ncur_r - count_use;
        end
        row_nxt = row_r + RAW'(1);
        if (row_r == RAW'(ROWS - 1)) begin
          cur_nxt   = FW'(ncur_nxt);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_CLRD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cur_r   <= '0;
      klen_r  <= '0;
      ovf_r   <= 1'b0;
      row_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      klen_r  <= klen_nxt;
      ovf_r   <= ovf_nxt;
      row_r   <= row_nxt;
      ov_r    <= ov_nxt;
    end
    clr_r    <= clr_nxt;
    ncur_r   <= ncur_nxt;
    bi_r     <= bi_nxt;
    h_r      <= h_nxt;
    round_r  <= round_nxt;
    rounds_r <= rounds_nxt;
    chk_r    <= chk_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    of_r     <= of_nxt;
    ok_r     <= ok_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.found        = of_r;
  assign out_ch.key_too_long = ok_r;

  rbf_ram #(.WIDTH(8), .DEPTH(MAX_KEY_BYTES)) u_keybuf (
    .clk     (clk),
    .wr_en   (kb_we),
    .wr_addr (klen_r[KAW-1:0]),
    .wr_data (in_ch.key_byte),
    .rd_en   (kb_re),
    .rd_addr (kb_raddr),
    .rd_data (kb_rdata)
  );

  rbf_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_filters (
    .clk     (clk),
    .wr_en   (fm_we),
    .wr_addr (fm_waddr),
    .wr_data (fm_wdata),
    .rd_en   (fm_re),
    .rd_addr (fm_raddr),
    .rd_data (fm_rdata)
  );

  rbf_mod #(.CW(CW), .IW(IW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (h_fin),
    .divisor  (bits_use),
    .done     (mod_done),
    .rem      (mod_rem)
  );
endmodule

[rtl/rbf_chk.sv]
// Port checker for the rotating Bloom filter, bound to the top level.
// Depends on rbf_pkg and rotating_bloom_filter_top.
module rbf_chk import rbf_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_cmd,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       cfg_ready
);
  a_init_blocks: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("word taken during filter clear after reset");

  a_rotate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_ROTATE) |=> !in_ready)
    else $error("word taken during rotate sweep");

  a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last && (in_cmd == CMD_INSERT || in_cmd == CMD_CHECK))
    |=> !in_ready)
    else $error("word taken while key is hashed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
endmodule

bind rotating_bloom_filter_top rbf_chk u_rbf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_ready (cfg_ch.ready)
);

[tb/sv/tb.sv]
// Testbench for rotating_bloom_filter_top: drives key words, rotates and register
// writes, and predicts found and key_too_long for every finished key.
// Depends on rbf_pkg, rbf_if and the block's RTL.
import rbf_pkg::*;

typedef struct packed {
  logic found;
  logic key_too_long;
} bloom_result_t;

typedef logic [7:0] key_bytes_t[$];

class bloom_scoreboard;
  bit             filt[MAX_FILTERS_DEF][FILTER_SIZE_DEF];
  bit [1:0]       cur_filter;
  logic [7:0]     key_buf[MAX_KEY_BYTES_DEF];
  int unsigned    key_len;
  bit             overflow;
  bit [31:0]      seed;
  bit [3:0]       rounds_reg;
  bit [14:0]      bits_reg;
  bit [2:0]       count_reg;
  bloom_result_t  awaited[$];
  int             errors;

  function new();
    seed = 0;
    rounds_reg = 5;
    bits_reg = 15'd16384;
    count_reg = 3;
    cur_filter = 0;
    key_len = 0;
    overflow = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    case (addr)
      REG_HASH_SEED:    seed = data;
      REG_HASH_COUNT:   rounds_reg = data[3:0];
      REG_FILTER_BITS:  bits_reg = data[14:0];
      REG_FILTER_COUNT: count_reg = data[2:0];
      default: ;
    endcase
  endfunction

  function bit [31:0] key_hash(bit [31:0] h_in);
    bit [31:0] h;
    h = h_in;
    for (int i = 0; i < key_len; i++) begin
      h = h + {24'd0, key_buf[i]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void note_word(cmd_t cmd, logic [7:0] kb, logic carries, logic last);
    int unsigned rounds, nbits, nfilt, idx;
    bit [31:0] h;
    bit hit;
    bloom_result_t r;
    if (cmd == CMD_ROTATE) begin
      nfilt = (count_reg == 0) ? 1 : (count_reg > MAX_FILTERS_DEF ? MAX_FILTERS_DEF : count_reg);
      for (int i = 0; i < FILTER_SIZE_DEF; i++) filt[cur_filter][i] = 0;
      cur_filter = 2'((cur_filter + 1) % nfilt);
      return;
    end
    if (cmd == CMD_NONE) return;
    if (carries) begin
      if (key_len < MAX_KEY_BYTES_DEF) begin
        key_buf[key_len] = kb;
        key_len++;
      end else begin
        overflow = 1;
      end
    end
    if (!last) return;
    rounds = (rounds_reg > MAX_HASHES_DEF) ? MAX_HASHES_DEF : rounds_reg;
    nbits = (bits_reg < 8) ? 8 : (bits_reg > FILTER_SIZE_DEF ? FILTER_SIZE_DEF : bits_reg);
    nfilt = (count_reg == 0) ? 1 : (count_reg > MAX_FILTERS_DEF ? MAX_FILTERS_DEF : count_reg);
    h = seed;
    hit = 1;
    for (int r_i = 0; r_i < rounds; r_i++) begin
      h = key_hash(h);
      idx = h % nbits;
      if (cmd == CMD_INSERT) begin
        for (int f = 0; f < nfilt; f++) filt[f][idx] = 1;
      end else if (!filt[cur_filter][idx]) begin
        hit = 0;
      end
    end
    r.found = (cmd == CMD_CHECK) && hit;
    r.key_too_long = overflow;
    awaited.push_back(r);
    key_len = 0;
    overflow = 0;
  endfunction

  function void check_result(logic found, logic too_long);
    bloom_result_t e;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result found=%b key_too_long=%b", $time, found, too_long);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (found !== e.found) begin
      $display("%0t: found mismatch, expected %b, actual %b", $time, e.found, found);
      errors++;
    end
    if (too_long !== e.key_too_long) begin
      $display("%0t: key_too_long mismatch, expected %b, actual %b", $time,
               e.key_too_long, too_long);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk;
  logic rst_n;
  bit   calm;
  int   words_sent;
  bloom_scoreboard sb;
  key_bytes_t pool[32];
  int pool_n;

  rbf_in_if  in_ch();
  rbf_out_if out_ch();
  rbf_cfg_if cfg_ch();

  rotating_bloom_filter_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(negedge clk) begin
    out_ch.ready = calm ? 1'b1 : ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.addr, cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.cmd, in_ch.key_byte, in_ch.carries_byte, in_ch.last);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.found, out_ch.key_too_long);
    end
  end

  task automatic send_word(cmd_t cmd, logic [7:0] kb, logic carries, logic last);
    if (!calm && $urandom_range(99) < 38) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_ch.cmd = cmd;
    in_ch.key_byte = kb;
    in_ch.carries_byte = carries;
    in_ch.last = last;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (cmd != CMD_NONE) words_sent++;
  endtask

  task automatic send_key(cmd_t cmd, key_bytes_t kq, bit mixed, bit noisy);
    cmd_t c;
    if (kq.size() == 0) begin
      send_word(cmd, 8'($urandom), 1'b0, 1'b1);
      return;
    end
    foreach (kq[i]) begin
      if (noisy && $urandom_range(9) == 0) send_word(cmd, 8'($urandom), 1'b0, 1'b0);
      c = (i == kq.size() - 1 || !mixed) ? cmd : cmd_t'($urandom_range(1));
      send_word(c, kq[i], 1'b1, i == kq.size() - 1);
    end
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    if (!calm && $urandom_range(99) < 38) begin
      cfg_ch.valid = 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    cfg_ch.addr = addr;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2 * FILTER_SIZE_DEF / 8 + 100) @(negedge clk);
  endtask

  task automatic configure(int phase);
    case (phase)
      1: begin
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_HASH_COUNT, 8);
        write_reg(REG_FILTER_BITS, 8);
        write_reg(REG_FILTER_COUNT, 1);
      end
      2: begin
        write_reg(REG_HASH_SEED, 32'hFFFF_FFFF);
        write_reg(REG_HASH_COUNT, 0);
        write_reg(REG_FILTER_BITS, 16384);
        write_reg(REG_FILTER_COUNT, 4);
      end
      3: begin
        write_reg(REG_HASH_COUNT, 15);
        write_reg(REG_FILTER_BITS, 3);
        write_reg(REG_FILTER_COUNT, 0);
        write_reg(4'd9, $urandom);
      end
      4: begin
        write_reg(REG_HASH_SEED, 0);
        write_reg(REG_HASH_COUNT, 1);
        write_reg(REG_FILTER_BITS, 15'h7FFF);
        write_reg(REG_FILTER_COUNT, 7);
      end
      default: begin
        write_reg(REG_HASH_SEED, $urandom);
        write_reg(REG_HASH_COUNT, $urandom_range(2, 4));
        write_reg(REG_FILTER_BITS, $urandom_range(9, 300));
        write_reg(REG_FILTER_COUNT, 2);
      end
    endcase
  endtask

  function automatic key_bytes_t fresh_key();
    key_bytes_t q;
    int n, p;
    p = $urandom_range(99);
    n = (p < 90) ? $urandom_range(6) : (p < 98 ? $urandom_range(20, 7) : $urandom_range(70, 60));
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  task automatic random_items(int stop_at);
    key_bytes_t kq;
    int p;
    cmd_t c;
    while (words_sent < stop_at) begin
      calm = (words_sent % 700) >= 320 && (words_sent % 700) < 420;
      p = $urandom_range(99);
      if (p < 3) begin
        send_word(CMD_ROTATE, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (p < 6) begin
        send_word(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        c = ($urandom_range(99) < 40) ? CMD_INSERT : CMD_CHECK;
        if (pool_n > 0 && $urandom_range(99) < 60) kq = pool[$urandom_range(pool_n - 1)];
        else kq = fresh_key();
        send_key(c, kq, $urandom_range(3) == 0, $urandom_range(4) == 0);
        if (c == CMD_INSERT) begin
          if (pool_n < 32) pool[pool_n++] = kq;
          else pool[$urandom_range(31)] = kq;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    key_bytes_t kq;
    sb = new();
    calm = 1'b0;
    words_sent = 0;
    pool_n = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_INSERT;
    in_ch.key_byte = '0;
    in_ch.carries_byte = 1'b0;
    in_ch.last = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.addr = '0;
    cfg_ch.data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_key(CMD_CHECK, kq, 0, 0);
    send_key(CMD_INSERT, kq, 0, 0);
    send_key(CMD_CHECK, kq, 0, 0);
    kq = '{8'h00, 8'hFF, 8'hA5};
    send_key(CMD_INSERT, kq, 0, 0);
    send_key(CMD_CHECK, kq, 1, 0);
    send_word(CMD_INSERT, 8'h5A, 1'b1, 1'b0);
    send_word(CMD_ROTATE, 8'hFF, 1'b1, 1'b1);
    send_word(CMD_NONE, 8'hFF, 1'b1, 1'b1);
    send_word(CMD_CHECK, 8'h00, 1'b0, 1'b0);
    send_word(CMD_INSERT, 8'hC3, 1'b1, 1'b1);
    send_key(CMD_CHECK, kq, 0, 0);
    send_word(CMD_ROTATE, 8'h00, 1'b0, 1'b0);
    send_word(CMD_ROTATE, 8'h00, 1'b0, 1'b0);
    send_key(CMD_CHECK, kq, 0, 0);
    kq = '{8'h5A, 8'hC3};
    send_key(CMD_CHECK, kq, 0, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        configure(ph);
      end
      if (ph == 2) begin
        kq = {};
        repeat (66) kq.push_back(8'($urandom));
        send_key(CMD_INSERT, kq, 1, 0);
        send_key(CMD_CHECK, kq, 0, 0);
      end
      random_items(words_sent + 90);
    end

    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2 * FILTER_SIZE_DEF / 8 + 100) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
